>>> rtl/dds_pkg.sv
// ----------------------------------------------------------------------------
// dds_pkg: shared types, constants and tables for the sine synthesizer
// Holds the channel count, phase width, queue entry layout and the note,
// sine and decay lookup tables used by the front and back parts.
// ----------------------------------------------------------------------------
package dds_pkg;

   localparam int CHANNELS   = 2;
   localparam int PHASE_BITS = 16;
   localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DELAY_W    = 13;

   localparam logic [7:0] SKIP_RESET   = 8'd100;
   localparam logic [7:0] SAMPLE_RESET = 8'h80;
   localparam logic [7:0] ENV_MAX      = 8'hFF;

   typedef enum logic {
      ACT_TICK  = 1'b0,
      ACT_EVENT = 1'b1
   } action_type;

   // one classified item as it travels from the front to the back part
   typedef struct packed {
      action_type                action;
      logic                      restart;
      logic                      ignored;
      logic [CH_W-1:0]           chan;
      logic [PHASE_BITS-1:0]     step;
      logic [DELAY_W-1:0]        delay;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   localparam logic [15:0] NOTE_STEPS [12] = '{
      16'hD7C7, 16'hCBAB, 16'hC03C, 16'hB573, 16'hAB43, 16'hA1A6,
      16'h9894, 16'h9003, 16'h87ED, 16'h804D, 16'h791A, 16'h724E
   };

   localparam logic [7:0] SINE_LUT [64] = '{
      8'h80, 8'h86, 8'h8C, 8'h92, 8'h98, 8'h9E, 8'hA3, 8'hA8,
      8'hAD, 8'hB1, 8'hB4, 8'hB8, 8'hBA, 8'hBC, 8'hBE, 8'hBF,
      8'hBF, 8'hBF, 8'hBE, 8'hBC, 8'hBA, 8'hB8, 8'hB4, 8'hB1,
      8'hAD, 8'hA8, 8'hA3, 8'h9E, 8'h98, 8'h92, 8'h8C, 8'h86,
      8'h80, 8'h7A, 8'h74, 8'h6E, 8'h68, 8'h62, 8'h5D, 8'h58,
      8'h53, 8'h4F, 8'h4C, 8'h48, 8'h46, 8'h44, 8'h42, 8'h41,
      8'h41, 8'h41, 8'h42, 8'h44, 8'h46, 8'h48, 8'h4C, 8'h4F,
      8'h53, 8'h58, 8'h5D, 8'h62, 8'h68, 8'h6E, 8'h74, 8'h7A
   };

   localparam logic [7:0] DECAY_LUT [128] = '{
      8'hFF, 8'hFA, 8'hF5, 8'hF0, 8'hEB, 8'hE7, 8'hE2, 8'hDE,
      8'hD9, 8'hD5, 8'hD1, 8'hCD, 8'hC9, 8'hC5, 8'hC1, 8'hBD,
      8'hB9, 8'hB6, 8'hB2, 8'hAE, 8'hAB, 8'hA8, 8'hA4, 8'hA1,
      8'h9E, 8'h9B, 8'h98, 8'h95, 8'h92, 8'h8F, 8'h8C, 8'h89,
      8'h86, 8'h84, 8'h81, 8'h7F, 8'h7C, 8'h7A, 8'h77, 8'h75,
      8'h73, 8'h70, 8'h6E, 8'h6C, 8'h6A, 8'h68, 8'h66, 8'h64,
      8'h62, 8'h60, 8'h5E, 8'h5C, 8'h5A, 8'h58, 8'h57, 8'h55,
      8'h53, 8'h52, 8'h50, 8'h4E, 8'h4D, 8'h4B, 8'h4A, 8'h48,
      8'h47, 8'h45, 8'h44, 8'h43, 8'h41, 8'h40, 8'h3F, 8'h3E,
      8'h3C, 8'h3B, 8'h3A, 8'h39, 8'h38, 8'h37, 8'h36, 8'h35,
      8'h33, 8'h32, 8'h31, 8'h30, 8'h30, 8'h2F, 8'h2E, 8'h2D,
      8'h2C, 8'h2B, 8'h2A, 8'h29, 8'h28, 8'h27, 8'h26, 8'h25,
      8'h23, 8'h22, 8'h21, 8'h20, 8'h1F, 8'h1E, 8'h1D, 8'h1C,
      8'h1A, 8'h19, 8'h18, 8'h17, 8'h16, 8'h15, 8'h14, 8'h13,
      8'h11, 8'h10, 8'h0F, 8'h0E, 8'h0D, 8'h0C, 8'h0B, 8'h0A,
      8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03, 8'h02, 8'h00
   };

   // phase step for a note: silence, minimal step, or octave-shifted table
   function automatic logic [PHASE_BITS-1:0] note_step(input logic [6:0] note);
      logic [7:0]  idx;
      logic [3:0]  oct;
      logic [7:0]  rem;
      logic [31:0] base;
      idx = 8'd131 - {1'b0, note};
      oct = '0;
      // octave = idx / 12 by threshold compares
      for (int k = 1; k <= 10; k++) begin
         if (idx >= 8'(12 * k)) begin
            oct = 4'(k);
         end
      end
      rem  = idx - 8'd12 * {4'b0, oct};
      base = {16'b0, NOTE_STEPS[rem[3:0]]} >> oct;
      if (note == 7'd0) begin
         return '0;
      end else if (note == 7'd1) begin
         return PHASE_BITS'(1);
      end
      return base[PHASE_BITS-1:0];
   endfunction

endpackage

>>> rtl/dds_front.sv
// ----------------------------------------------------------------------------
// dds_front: request intake and event decode
// Accepts request beats while the queue has room, splits event words into
// channel, delay and note, and looks up the phase step for the note.
// ----------------------------------------------------------------------------
module dds_front (
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [15:0]            req_delta_channel,
   input  logic [7:0]             req_note_byte,
   input  dds_pkg::q_status_type  q_status,
   output logic                   push,
   output dds_pkg::entry_type     push_entry
);

   logic [3:0]                  chan_full;
   logic [dds_pkg::DELAY_W-1:0] delay;

   // hold off new beats while the queue is full
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // decode the event word
   assign chan_full = {req_note_byte[7], req_delta_channel[2:0]};
   assign delay     = req_delta_channel[15:3];

   always_comb begin
      push_entry.action  = req_action ? dds_pkg::ACT_EVENT : dds_pkg::ACT_TICK;
      push_entry.restart = (delay == '0);
      push_entry.ignored = (delay != '0) && ({1'b0, chan_full} >= 5'(dds_pkg::CHANNELS));
      push_entry.chan    = chan_full[dds_pkg::CH_W-1:0];
      push_entry.step    = dds_pkg::note_step(req_note_byte[6:0]);
      push_entry.delay   = delay;
   end

endmodule

>>> rtl/dds_queue.sv
// ----------------------------------------------------------------------------
// dds_queue: two-entry queue between front and back
// Decouples request intake from execution so each side stalls on its own.
// ----------------------------------------------------------------------------
module dds_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dds_pkg::entry_type     push_entry,
   input  logic                   pop,
   output dds_pkg::entry_type     head_entry,
   output dds_pkg::q_status_type  q_status
);

   dds_pkg::entry_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign head_entry     = slot_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == 2'd2);
   assign q_status.empty = (count_ff == 2'd0);

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/dds_back.sv
// ----------------------------------------------------------------------------
// dds_back: tick and event execution
// Runs envelope and countdown steps, walks the channels one per cycle to
// build the mixed sample, applies note events, and holds the response beat.
// ----------------------------------------------------------------------------
module dds_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  dds_pkg::entry_type    head_entry,
   output logic                  pop,
   input  logic [7:0]            skip_max,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_sample,
   output logic                  rsp_event_request,
   output logic                  rsp_restart,
   output logic                  rsp_channel_ignored
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CHAN = 3'b010,
      ST_DONE = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [dds_pkg::PHASE_BITS-1:0] acc_ff  [dds_pkg::CHANNELS];
   logic [dds_pkg::PHASE_BITS-1:0] acc_in  [dds_pkg::CHANNELS];
   logic [dds_pkg::PHASE_BITS-1:0] step_ff [dds_pkg::CHANNELS];
   logic [dds_pkg::PHASE_BITS-1:0] step_in [dds_pkg::CHANNELS];
   logic [7:0]                     env_ff  [dds_pkg::CHANNELS];
   logic [7:0]                     env_in  [dds_pkg::CHANNELS];

   logic [7:0]            skip_ff, skip_in;
   logic [15:0]           cd_ff, cd_in;
   logic [7:0]            last_ff, last_in;
   logic                  pending_ff, pending_in;
   logic [7:0]            mix_ff, mix_in;
   logic [dds_pkg::CH_W-1:0] ch_ff, ch_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_sample_ff, rsp_sample_in;
   logic                  rsp_req_ff, rsp_req_in;
   logic                  rsp_restart_ff, rsp_restart_in;
   logic                  rsp_ignored_ff, rsp_ignored_in;

   logic                           out_free;
   logic [dds_pkg::PHASE_BITS-1:0] phase_sum;
   logic [7:0]                     sine_val;
   logic [7:0]                     env_val;
   logic [15:0]                    prod;
   logic [7:0]                     term;
   logic [7:0]                     mix_next;
   logic [15:0]                    cd_dec;
   logic [7:0]                     skip_load;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sample          = rsp_sample_ff;
   assign rsp_event_request   = rsp_req_ff;
   assign rsp_restart         = rsp_restart_ff;
   assign rsp_channel_ignored = rsp_ignored_ff;

   // one channel's scaled sine contribution
   always_comb begin
      phase_sum = acc_ff[ch_ff] + step_ff[ch_ff];
      sine_val  = dds_pkg::SINE_LUT[phase_sum[dds_pkg::PHASE_BITS-1 -: 6]];
      env_val   = dds_pkg::DECAY_LUT[env_ff[ch_ff][7:1]];
      prod      = {8'b0, sine_val} * {8'b0, env_val};
      term      = prod[15:8] - {1'b0, env_val[7:1]};
      mix_next  = mix_ff + term;
      cd_dec    = cd_ff - 16'd1;
   end

   // sequence ticks and events
   always_comb begin
      state_in       = state_ff;
      acc_in         = acc_ff;
      step_in        = step_ff;
      env_in         = env_ff;
      skip_in        = skip_ff;
      cd_in          = cd_ff;
      last_in        = last_ff;
      pending_in     = pending_ff;
      mix_in         = mix_ff;
      ch_in          = ch_ff;
      pop            = 1'b0;
      skip_load      = skip_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_sample_in  = rsp_sample_ff;
      rsp_req_in     = rsp_req_ff;
      rsp_restart_in = rsp_restart_ff;
      rsp_ignored_in = rsp_ignored_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty && head_entry.action == dds_pkg::ACT_TICK) begin
               pop = 1'b1;
               // envelope and countdown step when the skip counter runs out
               if (skip_ff == 8'd0) begin
                  skip_load = skip_max;
                  for (int c = 0; c < dds_pkg::CHANNELS; c++) begin
                     if (env_ff[c] != dds_pkg::ENV_MAX) begin
                        env_in[c] = env_ff[c] + 8'd1;
                     end
                  end
                  cd_in = cd_dec;
                  if (cd_dec == 16'd0) begin
                     pending_in = 1'b1;
                  end
               end
               skip_in  = skip_load - 8'd1;
               mix_in   = dds_pkg::SAMPLE_RESET;
               ch_in    = '0;
               state_in = ST_CHAN;
            end else if (!q_empty && out_free) begin
               pop        = 1'b1;
               pending_in = 1'b0;
               if (head_entry.restart) begin
                  for (int c = 0; c < dds_pkg::CHANNELS; c++) begin
                     acc_in[c]  = '0;
                     step_in[c] = '0;
                     env_in[c]  = '0;
                  end
                  cd_in   = 16'd1;
                  skip_in = 8'd0;
               end else begin
                  if (!head_entry.ignored) begin
                     acc_in[head_entry.chan]  = '0;
                     step_in[head_entry.chan] = head_entry.step;
                     env_in[head_entry.chan]  = '0;
                  end
                  cd_in = {3'b0, head_entry.delay};
               end
               rsp_valid_in   = 1'b1;
               rsp_sample_in  = last_ff;
               rsp_req_in     = 1'b0;
               rsp_restart_in = head_entry.restart;
               rsp_ignored_in = head_entry.ignored;
            end
         end
         ST_CHAN: begin
            // advance one channel's phase and fold it into the mix
            acc_in[ch_ff] = phase_sum;
            mix_in        = mix_next;
            if (ch_ff == dds_pkg::CH_W'(dds_pkg::CHANNELS - 1)) begin
               last_in  = mix_next;
               state_in = ST_DONE;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end
         ST_DONE: begin
            // hold the tick result until the response register is free
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_sample_in  = last_ff;
               rsp_req_in     = pending_ff;
               rsp_restart_in = 1'b0;
               rsp_ignored_in = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         for (int c = 0; c < dds_pkg::CHANNELS; c++) begin
            acc_ff[c]  <= '0;
            step_ff[c] <= '0;
            env_ff[c]  <= '0;
         end
         skip_ff      <= 8'd0;
         cd_ff        <= 16'd1;
         last_ff      <= dds_pkg::SAMPLE_RESET;
         pending_ff   <= 1'b0;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         step_ff      <= step_in;
         env_ff       <= env_in;
         skip_ff      <= skip_in;
         cd_ff        <= cd_in;
         last_ff      <= last_in;
         pending_ff   <= pending_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mix_ff         <= mix_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_req_ff     <= rsp_req_in;
      rsp_restart_ff <= rsp_restart_in;
      rsp_ignored_ff <= rsp_ignored_in;
   end

endmodule

>>> rtl/dds_sine_synth_with_envelope.sv
// Flow: a tick beat passes the queue, the envelope and countdown step, the
//   per-channel mix walk and the result state; an event goes from the queue head.
// Throughput: the back part takes no new tick until the per-channel mix loop
//   of the last one is done; events issue one per cycle while the response is free.
// Reset: synchronous; channels clear, countdown is one, sample reads 0x80,
//   the skip period register returns to 100. No clearing pass is needed.
// ----------------------------------------------------------------------------
// dds_sine_synth_with_envelope: multi-channel sine synthesizer, top level
// Front decodes request beats into a short queue; the back part executes
// ticks and note events and holds one response beat.
// ----------------------------------------------------------------------------
module dds_sine_synth_with_envelope (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_delta_channel,
   input  logic [7:0]  req_note_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_sample,
   output logic        rsp_event_request,
   output logic        rsp_restart,
   output logic        rsp_channel_ignored,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_skip_period
);

   dds_pkg::q_status_type q_status;
   dds_pkg::entry_type    push_entry;
   dds_pkg::entry_type    head_entry;
   logic                  push;
   logic                  pop;
   logic [7:0]            skip_max_ff;

   // take register writes at any time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_max_ff <= dds_pkg::SKIP_RESET;
      end else if (csr_valid && csr_ready) begin
         skip_max_ff <= csr_skip_period;
      end
   end

   dds_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_delta_channel (req_delta_channel),
      .req_note_byte     (req_note_byte),
      .q_status          (q_status),
      .push              (push),
      .push_entry        (push_entry)
   );

   dds_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   dds_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_status.empty),
      .head_entry          (head_entry),
      .pop                 (pop),
      .skip_max            (skip_max_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sample          (rsp_sample),
      .rsp_event_request   (rsp_event_request),
      .rsp_restart         (rsp_restart),
      .rsp_channel_ignored (rsp_channel_ignored)
   );

endmodule

>>> bench/dds_sine_synth_with_envelope_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dds_sine_synth_with_envelope_tb: self-checking bench for the sine synthesizer
// Drives tick and note-event beats in random bursts against a stalling
// receiver. A scoreboard class tracks phases, envelopes and the event
// countdown, and checks every response beat field by field.
// ----------------------------------------------------------------------------
module dds_sine_synth_with_envelope_tb;

   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_LIMIT = 20000;
   localparam logic [7:0] MIX_BASE = 8'h80;

   localparam logic [15:0] TONE_STEP [12] = '{
      16'hD7C7, 16'hCBAB, 16'hC03C, 16'hB573, 16'hAB43, 16'hA1A6,
      16'h9894, 16'h9003, 16'h87ED, 16'h804D, 16'h791A, 16'h724E
   };

   localparam logic [7:0] SINE_ROM [64] = '{
      8'h80, 8'h86, 8'h8C, 8'h92, 8'h98, 8'h9E, 8'hA3, 8'hA8,
      8'hAD, 8'hB1, 8'hB4, 8'hB8, 8'hBA, 8'hBC, 8'hBE, 8'hBF,
      8'hBF, 8'hBF, 8'hBE, 8'hBC, 8'hBA, 8'hB8, 8'hB4, 8'hB1,
      8'hAD, 8'hA8, 8'hA3, 8'h9E, 8'h98, 8'h92, 8'h8C, 8'h86,
      8'h80, 8'h7A, 8'h74, 8'h6E, 8'h68, 8'h62, 8'h5D, 8'h58,
      8'h53, 8'h4F, 8'h4C, 8'h48, 8'h46, 8'h44, 8'h42, 8'h41,
      8'h41, 8'h41, 8'h42, 8'h44, 8'h46, 8'h48, 8'h4C, 8'h4F,
      8'h53, 8'h58, 8'h5D, 8'h62, 8'h68, 8'h6E, 8'h74, 8'h7A
   };

   localparam logic [7:0] DECAY_ROM [128] = '{
      8'hFF, 8'hFA, 8'hF5, 8'hF0, 8'hEB, 8'hE7, 8'hE2, 8'hDE,
      8'hD9, 8'hD5, 8'hD1, 8'hCD, 8'hC9, 8'hC5, 8'hC1, 8'hBD,
      8'hB9, 8'hB6, 8'hB2, 8'hAE, 8'hAB, 8'hA8, 8'hA4, 8'hA1,
      8'h9E, 8'h9B, 8'h98, 8'h95, 8'h92, 8'h8F, 8'h8C, 8'h89,
      8'h86, 8'h84, 8'h81, 8'h7F, 8'h7C, 8'h7A, 8'h77, 8'h75,
      8'h73, 8'h70, 8'h6E, 8'h6C, 8'h6A, 8'h68, 8'h66, 8'h64,
      8'h62, 8'h60, 8'h5E, 8'h5C, 8'h5A, 8'h58, 8'h57, 8'h55,
      8'h53, 8'h52, 8'h50, 8'h4E, 8'h4D, 8'h4B, 8'h4A, 8'h48,
      8'h47, 8'h45, 8'h44, 8'h43, 8'h41, 8'h40, 8'h3F, 8'h3E,
      8'h3C, 8'h3B, 8'h3A, 8'h39, 8'h38, 8'h37, 8'h36, 8'h35,
      8'h33, 8'h32, 8'h31, 8'h30, 8'h30, 8'h2F, 8'h2E, 8'h2D,
      8'h2C, 8'h2B, 8'h2A, 8'h29, 8'h28, 8'h27, 8'h26, 8'h25,
      8'h23, 8'h22, 8'h21, 8'h20, 8'h1F, 8'h1E, 8'h1D, 8'h1C,
      8'h1A, 8'h19, 8'h18, 8'h17, 8'h16, 8'h15, 8'h14, 8'h13,
      8'h11, 8'h10, 8'h0F, 8'h0E, 8'h0D, 8'h0C, 8'h0B, 8'h0A,
      8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03, 8'h02, 8'h00
   };

   typedef enum int {
      RX_OPEN,
      RX_RANDOM,
      RX_PERIODIC
   } rx_mode_type;

   typedef struct packed {
      logic [7:0] duty;
      logic       req;
      logic       rst;
      logic       ign;
   } synth_beat_type;

   // tracks the synthesizer state and the response beats still owed
   class synth_scoreboard_type;
      logic [15:0]    acc [dds_pkg::CHANNELS];
      logic [15:0]    inc [dds_pkg::CHANNELS];
      logic [7:0]     env [dds_pkg::CHANNELS];
      logic [7:0]     skip_cnt;
      logic [7:0]     skip_max;
      logic [7:0]     last_duty;
      logic [15:0]    countdown;
      bit             request_pending;
      synth_beat_type pending_results [$];
      int             mismatches;

      function new();
         clear_voices();
         last_duty       = MIX_BASE;
         request_pending = 1'b0;
         skip_max        = dds_pkg::SKIP_RESET;
         mismatches      = 0;
      endfunction

      function void clear_voices();
         for (int c = 0; c < dds_pkg::CHANNELS; c++) begin
            acc[c] = '0;
            inc[c] = '0;
            env[c] = '0;
         end
         countdown = 16'd1;
         skip_cnt  = 8'd0;
      endfunction

      // silence, minimal step, or the octave-shifted note table
      function logic [15:0] tone_increment(logic [6:0] note);
         int idx;
         int octave;
         if (note == 7'd0) return 16'd0;
         if (note == 7'd1) return 16'd1;
         idx    = 131 - int'(note);
         octave = idx / 12;
         return TONE_STEP[idx % 12] >> octave;
      endfunction

      // one sample tick: envelope step, phase advance and mix
      function void advance_tick();
         logic [7:0]  mix;
         logic [7:0]  tone;
         logic [7:0]  level;
         logic [15:0] prod;
         if (skip_cnt == 8'd0) begin
            skip_cnt = skip_max;
            for (int c = 0; c < dds_pkg::CHANNELS; c++) begin
               if (env[c] != dds_pkg::ENV_MAX) env[c] = env[c] + 8'd1;
            end
            countdown = countdown - 16'd1;
            if (countdown == 16'd0) request_pending = 1'b1;
         end
         skip_cnt = skip_cnt - 8'd1;
         mix = MIX_BASE;
         for (int c = 0; c < dds_pkg::CHANNELS; c++) begin
            acc[c] = acc[c] + inc[c];
            level  = DECAY_ROM[env[c][7:1]];
            prod   = {8'b0, SINE_ROM[acc[c][15:10]]} * {8'b0, level};
            tone   = prod[15:8] - {1'b0, level[7:1]};
            mix    = mix + tone;
         end
         last_duty = mix;
      endfunction

      // note an accepted request beat and queue the response it owes
      function void note_beat(logic action, logic [15:0] word, logic [7:0] nb);
         synth_beat_type             beat;
         logic [3:0]                 ch;
         logic [dds_pkg::CH_W-1:0]   slot;
         beat.rst = 1'b0;
         beat.ign = 1'b0;
         if (action == dds_pkg::ACT_TICK) begin
            advance_tick();
         end else begin
            request_pending = 1'b0;
            if (word[15:3] == 13'd0) begin
               clear_voices();
               beat.rst = 1'b1;
            end else begin
               ch = {nb[7], word[2:0]};
               if (ch < dds_pkg::CHANNELS) begin
                  slot      = ch[dds_pkg::CH_W-1:0];
                  acc[slot] = '0;
                  inc[slot] = tone_increment(nb[6:0]);
                  env[slot] = '0;
               end else begin
                  beat.ign = 1'b1;
               end
               countdown = {3'b000, word[15:3]};
            end
         end
         beat.duty = last_duty;
         beat.req  = request_pending;
         pending_results.push_back(beat);
      endfunction

      task report_mismatch(string what, int got, int want);
         mismatches++;
         $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
      endtask

      // compare one response beat with the oldest one owed
      task check_beat(logic [7:0] duty, logic req, logic rst, logic ign);
         synth_beat_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("response beat with none owed", duty, 0);
            return;
         end
         want = pending_results.pop_front();
         if (duty !== want.duty) report_mismatch("sample", duty, want.duty);
         if (req !== want.req) report_mismatch("event_request", req, want.req);
         if (rst !== want.rst) report_mismatch("restart", rst, want.rst);
         if (ign !== want.ign) report_mismatch("channel_ignored", ign, want.ign);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [15:0] req_delta_channel;
   logic [7:0]  req_note_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_sample;
   logic        rsp_event_request;
   logic        rsp_restart;
   logic        rsp_channel_ignored;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_skip_period;

   synth_scoreboard_type tracker;
   int                   burst_left = 0;
   bit                   hold_go = 1'b0;

   dds_sine_synth_with_envelope dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_delta_channel   (req_delta_channel),
      .req_note_byte       (req_note_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sample          (rsp_sample),
      .rsp_event_request   (rsp_event_request),
      .rsp_restart         (rsp_restart),
      .rsp_channel_ignored (rsp_channel_ignored),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_skip_period     (csr_skip_period)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // drop valid for a random gap at the end of each burst
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = $urandom_range(1, 8);
         burst_left = $urandom_range(0, 40);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // offer one request beat and hold it until accepted
   task automatic send_beat(logic action, logic [15:0] word, logic [7:0] nb);
      req_valid         <= 1'b1;
      req_action        <= action;
      req_delta_channel <= word;
      req_note_byte     <= nb;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      tracker.note_beat(action, word, nb);
      pace();
   endtask

   task automatic send_tick();
      send_beat(dds_pkg::ACT_TICK, 16'($urandom), 8'($urandom));
   endtask

   task automatic send_event(int delay, int ch, int note);
      logic [3:0] c4;
      c4 = 4'(ch);
      send_beat(dds_pkg::ACT_EVENT, {13'(delay), c4[2:0]}, {c4[3], 7'(note)});
   endtask

   // mostly answer pending requests; otherwise tick, with stray events as noise
   task automatic send_random(bit quiet);
      int roll;
      int delay;
      int ch;
      int note;
      roll = $urandom_range(0, 99);
      if (!quiet && ((tracker.request_pending && roll < 75) ||
                     $urandom_range(0, 99) < 4)) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) delay = 0;
         else if (roll < 92) delay = $urandom_range(1, 6);
         else delay = $urandom_range(1, 8191);
         if ($urandom_range(0, 99) < 80) ch = $urandom_range(0, dds_pkg::CHANNELS - 1);
         else ch = $urandom_range(0, 15);
         if ($urandom_range(0, 9) == 0) note = $urandom_range(0, 1);
         else note = $urandom_range(0, 127);
         send_event(delay, ch, note);
      end else begin
         send_tick();
      end
   endtask

   // hold the sender until every owed response beat is in
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic write_skip(logic [7:0] value);
      drain();
      csr_valid       <= 1'b1;
      csr_skip_period <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      tracker.skip_max = value;
   endtask

   task automatic run_phase(logic [7:0] value, int count, int quiet_count, int hold_at);
      write_skip(value);
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) hold_go = 1'b1;
         send_random(i < quiet_count);
      end
   endtask

   // note extremes, channel decode corners and the zero-delay restart
   task automatic directed();
      send_tick();
      send_tick();
      send_event(1, 0, 0);
      send_tick();
      send_tick();
      send_event(2, 1, 1);
      send_tick();
      send_event(3, 0, 2);
      send_event(1, 1, 127);
      send_tick();
      send_tick();
      send_tick();
      send_event(4, 2, 60);
      send_event(4, 8, 33);
      send_beat(dds_pkg::ACT_EVENT, 16'hFFFF, 8'hFF);
      send_tick();
      send_tick();
      send_beat(dds_pkg::ACT_EVENT, 16'h0007, 8'hFF);
      send_tick();
      send_tick();
      send_event(8191, 0, 69);
      send_event(5, 1, 13);
      send_tick();
      send_tick();
      send_tick();
   endtask

   // main sequence
   initial begin
      tracker = new();
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_action        <= dds_pkg::ACT_TICK;
      req_delta_channel <= '0;
      req_note_byte     <= '0;
      csr_valid         <= 1'b0;
      csr_skip_period   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      directed();
      // long tick-only stretch first so envelopes saturate
      run_phase(8'd1, 500, 300, -1);
      run_phase(8'd255, 200, 0, -1);
      run_phase(8'd0, 250, 0, -1);
      run_phase(8'd3, 400, 0, 100);
      run_phase(8'($urandom_range(2, 254)), 350, 0, -1);
      run_phase(8'd1, 200, 0, -1);
      drain();
      repeat (dds_pkg::CHANNELS + 8) @(posedge clock);
      if (tracker.pending_results.size() != 0)
         tracker.report_mismatch("response beats never arrived",
                                 tracker.pending_results.size(), 0);
      if (tracker.mismatches == 0) begin
         $display("dds_sine_synth_with_envelope_tb: PASS");
      end else begin
         $display("dds_sine_synth_with_envelope_tb: FAIL");
      end
      $finish;
   end

   // receiver: open, random and periodic stall segments, plus one long hold-off
   initial begin
      int          seg_left;
      int          period;
      int          phase_cnt;
      int          hold_left;
      rx_mode_type mode;
      seg_left  = 0;
      period    = 2;
      phase_cnt = 0;
      hold_left = 0;
      mode      = RX_OPEN;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               mode     = rx_mode_type'($urandom_range(0, 2));
               seg_left = $urandom_range(8, 120);
               period   = $urandom_range(2, 7);
            end
            seg_left--;
            phase_cnt++;
            case (mode)
               RX_OPEN: begin
                  rsp_stall <= 1'b0;
               end
               RX_RANDOM: begin
                  rsp_stall <= ($urandom_range(0, 99) < 40);
               end
               default: begin
                  rsp_stall <= ((phase_cnt % period) < (period / 2));
               end
            endcase
         end
      end
   end

   // check each accepted response beat
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         tracker.check_beat(rsp_sample, rsp_event_request, rsp_restart,
                            rsp_channel_ignored);
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #8000000;
      $display("dds_sine_synth_with_envelope_tb: FAIL");
      $finish;
   end

endmodule

>>> dds_sine_synth_with_envelope.f
rtl/dds_pkg.sv
rtl/dds_front.sv
rtl/dds_queue.sv
rtl/dds_back.sv
rtl/dds_sine_synth_with_envelope.sv
bench/dds_sine_synth_with_envelope_tb.sv
